@@ src/tbs_pkg.sv @@
// Shared types and constants for the token bucket shaper.
// No dependencies; used by every module under src.
package tbs_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;

  localparam int DATA_W = 24;   // widest configuration register
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BACKLOG  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_DEPTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SHIFT   = 2'd2;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_TBL_WR  = 2'd2,
    OP_FLUSH   = 2'd3
  } op_t;

  // Item held in the update stage while its cost word comes out of memory
  typedef struct packed {
    op_t         op;
    logic [31:0] now;
    logic [15:0] len;
    logic        head;
  } item_t;

  // One result transfer
  typedef struct packed {
    logic        admitted;
    logic        send_now;
    logic [23:0] wait_us;
    logic [23:0] backlog;
  } result_t;

endpackage

@@ src/tbs_cost_mem.sv @@
// Cost table: one synchronous memory, written and read when an item is taken.
// Depends on tbs_pkg for the operation codes.
module tbs_cost_mem #(
  parameter int TABLE_ENTRIES = tbs_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        take,
  input  tbs_pkg::op_t op,
  input  logic [15:0] packet_length,
  input  logic [3:0]  cell_shift,
  input  logic [7:0]  entry_index,
  input  logic [23:0] entry_value,
  output logic [23:0] cost
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int EW = (IDX_W > 8) ? IDX_W : 8;
  localparam int LW = (IDX_W > 16) ? IDX_W : 16;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(TABLE_ENTRIES - 1);

  logic [23:0] mem [TABLE_ENTRIES];

  logic [15:0]    shifted;
  logic [LW-1:0]  shifted_ext;
  logic [EW-1:0]  entry_ext;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic           wr_en;

  // Saturate the cell index at the last entry
  always_comb begin
    shifted     = packet_length >> cell_shift;
    shifted_ext = LW'(shifted);
    if (32'(shifted) > 32'(TABLE_ENTRIES - 1)) begin
      rd_addr = IDX_MAX;
    end else begin
      rd_addr = shifted_ext[IDX_W-1:0];
    end
    entry_ext = EW'(entry_index);
    wr_addr   = entry_ext[IDX_W-1:0];
    wr_en     = take && (op == tbs_pkg::OP_TBL_WR) &&
                (32'(entry_index) < 32'(TABLE_ENTRIES));
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= entry_value;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cost <= mem[rd_addr];
    end
  end

endmodule

@@ src/tbs_update.sv @@
// Scalar shaper state (backlog, tokens, checkpoint) and the per-item decision.
// Depends on tbs_pkg for item and result types.
module tbs_update (
  input  logic             clk,
  input  logic             rst,
  input  logic             commit,
  input  tbs_pkg::item_t   item,
  input  logic [23:0]      cost,
  input  logic [23:0]      max_backlog,
  input  logic [23:0]      bucket_depth,
  output tbs_pkg::result_t result
);

  logic [23:0] backlog_bytes, backlog_bytes_next;
  logic [23:0] token_level, token_level_next;
  logic [31:0] checkpoint_time, checkpoint_time_next;

  logic [24:0] enq_sum;
  logic [31:0] elapsed;
  logic [23:0] earned;
  logic [24:0] avail;
  logic [25:0] diff;
  logic [25:0] short;

  always_comb begin
    enq_sum = {1'b0, backlog_bytes} + 25'(item.len);
    elapsed = item.now - checkpoint_time;
    earned  = (elapsed > {8'd0, bucket_depth}) ? bucket_depth : elapsed[23:0];
    avail   = {1'b0, earned} + {1'b0, token_level};
    diff    = {1'b0, avail} - {2'b00, cost};
    short   = {2'b00, cost} - {1'b0, avail};

    backlog_bytes_next   = backlog_bytes;
    token_level_next     = token_level;
    checkpoint_time_next = checkpoint_time;
    result               = '0;

    unique case (item.op)
      tbs_pkg::OP_ENQUEUE: begin
        if (enq_sum <= {1'b0, max_backlog}) begin
          backlog_bytes_next = enq_sum[23:0];
          result.admitted    = 1'b1;
        end
      end
      tbs_pkg::OP_DEQUEUE: begin
        if (item.head) begin
          if (!diff[25]) begin
            checkpoint_time_next = item.now;
            token_level_next = (diff[24:0] <= {1'b0, bucket_depth}) ?
                               diff[23:0] : bucket_depth;
            backlog_bytes_next = ({8'd0, item.len} >= backlog_bytes) ?
                                 24'd0 : backlog_bytes - 24'(item.len);
            result.send_now = 1'b1;
          end else begin
            result.wait_us = short[23:0];
          end
        end
      end
      tbs_pkg::OP_TBL_WR: begin
      end
      tbs_pkg::OP_FLUSH: begin
        backlog_bytes_next   = 24'd0;
        checkpoint_time_next = item.now;
        token_level_next     = bucket_depth;
      end
      default: begin
      end
    endcase

    result.backlog = backlog_bytes_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      backlog_bytes   <= 24'd0;
      token_level     <= 24'd0;
      checkpoint_time <= 32'd0;
    end else if (commit) begin
      backlog_bytes   <= backlog_bytes_next;
      token_level     <= token_level_next;
      checkpoint_time <= checkpoint_time_next;
    end
  end

endmodule

@@ src/token_bucket_shaper.sv @@
// The table read is registered with the item; the decision is then registered at the output.
// One item per cycle when out_stall is low; the cost table port is used once per item.
// The cost table read is registered, so the update stage always sees a settled cost word.
// Reset (rst, synchronous) clears backlog, tokens, checkpoint, config registers and valids.
// The cost table is not cleared: entries are undefined until a table write loads them.
module token_bucket_shaper #(
  parameter int TABLE_ENTRIES = tbs_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [31:0] now,
  input  logic [15:0] packet_length,
  input  logic        head_present,
  input  logic [7:0]  entry_index,
  input  logic [23:0] entry_value,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        admitted,
  output logic        send_now,
  output logic [23:0] wait_us,
  output logic [23:0] backlog,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [tbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tbs_pkg::DATA_W-1:0]    cfg_data
);

  // Configuration registers
  logic [23:0] max_backlog;
  logic [23:0] bucket_depth;
  logic [3:0]  cell_shift;

  // Update stage: item whose cost word is being read
  logic            s1_valid;
  tbs_pkg::item_t  s1_item;
  logic [23:0]     s1_cost;
  tbs_pkg::result_t s1_result;

  logic in_take;
  logic out_free;
  logic s1_move;

  // The output register frees when it is empty or its transfer completes.
  // The update stage moves into it then; a new item may enter in the same cycle.
  assign out_free = !out_valid || !out_stall;
  assign s1_move  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  // Configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      max_backlog  <= 24'd0;
      bucket_depth <= 24'd0;
      cell_shift   <= 4'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tbs_pkg::REG_MAX_BACKLOG:  max_backlog  <= cfg_data[23:0];
        tbs_pkg::REG_BUCKET_DEPTH: bucket_depth <= cfg_data[23:0];
        tbs_pkg::REG_CELL_SHIFT:   cell_shift   <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // Cost table: the read is launched at the input transfer, so it sees every
  // table write from earlier items and needs no forwarding.
  tbs_cost_mem #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_cost_mem (
    .clk          (clk),
    .take         (in_take),
    .op           (tbs_pkg::op_t'(op)),
    .packet_length(packet_length),
    .cell_shift   (cell_shift),
    .entry_index  (entry_index),
    .entry_value  (entry_value),
    .cost         (s1_cost)
  );

  // Hold the item beside its pending cost read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item.op   <= tbs_pkg::op_t'(op);
      s1_item.now  <= now;
      s1_item.len  <= packet_length;
      s1_item.head <= head_present;
    end
  end

  // Decision and scalar state; state advances only when the result moves on,
  // so back-to-back items each see the state left by the one before.
  tbs_update u_update (
    .clk         (clk),
    .rst         (rst),
    .commit      (s1_move),
    .item        (s1_item),
    .cost        (s1_cost),
    .max_backlog (max_backlog),
    .bucket_depth(bucket_depth),
    .result      (s1_result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      admitted <= s1_result.admitted;
      send_now <= s1_result.send_now;
      wait_us  <= s1_result.wait_us;
      backlog  <= s1_result.backlog;
    end
  end

  // A stall toward the source only comes from a full update stage
  a_stall_has_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty update stage");

  // An item leaving the update stage must show up at the output
  a_move_lands: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> out_valid)
    else $error("result lost between update stage and output");

  // Admission and release never come from the same item
  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(admitted && send_now))
    else $error("admitted and send_now both set");

  // A release carries no shortfall
  a_send_no_wait: assert property (@(posedge clk) disable iff (rst)
    (out_valid && send_now) |-> (wait_us == 24'd0))
    else $error("send_now with nonzero wait");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for token_bucket_shaper: directed rows, then random phases.
// Depends on tbs_pkg (op codes, register indexes, result type) and the shaper RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int CLK_HALF    = 10;
  localparam int RST_CYCLES  = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 155;
  localparam int PRINT_CAP   = 50;
  localparam int SIDE_SRC    = 0;
  localparam int SIDE_SINK   = 1;

  // Index 3 decodes to no register; a write there must change nothing.
  localparam logic [tbs_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  // One command as presented on the input channel
  typedef struct packed {
    tbs_pkg::op_t op;
    logic [31:0]  now;
    logic [15:0]  len;
    logic         head;
    logic [7:0]   entry_index;
    logic [23:0]  entry_value;
  } shaper_cmd_t;

  // Directed row: either a register write or a command, optionally with a
  // hand-written result that replaces the predicted one
  typedef struct packed {
    bit               reg_wr;
    logic [1:0]       reg_idx;
    logic [23:0]      reg_val;
    shaper_cmd_t      cmd;
    bit               known;
    tbs_pkg::result_t want;
  } stim_row_t;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [1:0]                    op = 2'd0;
  logic [31:0]                   now = 32'd0;
  logic [15:0]                   packet_length = 16'd0;
  logic                          head_present = 1'b0;
  logic [7:0]                    entry_index = 8'd0;
  logic [23:0]                   entry_value = 24'd0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          admitted;
  logic                          send_now;
  logic [23:0]                   wait_us;
  logic [23:0]                   backlog;
  logic                          cfg_we = 1'b0;
  logic [tbs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tbs_pkg::DATA_W-1:0]    cfg_data = '0;

  token_bucket_shaper u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .now           (now),
    .packet_length (packet_length),
    .head_present  (head_present),
    .entry_index   (entry_index),
    .entry_value   (entry_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .admitted      (admitted),
    .send_now      (send_now),
    .wait_us       (wait_us),
    .backlog       (backlog),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Shaper state as the testbench sees it
  // ---------------------------------------------------------------------
  logic [23:0] max_backlog_q;
  logic [23:0] depth_q;
  logic [3:0]  shift_q;
  logic [23:0] backlog_q;
  logic [23:0] tokens_q;
  logic [31:0] checkpoint_q;
  logic [23:0] cost_q [256];
  bit   [255:0] cost_loaded;   // dequeues only ever read loaded entries

  tbs_pkg::result_t shaper_results[$];  // results awaited, oldest first
  stim_row_t   stim_rows[$];
  int          mismatches;
  int          cycle_count;
  int          calm_left[2];       // remaining no-idle stretch per side
  logic [31:0] clock_us;           // free-running time for random commands

  // Table index of a packet: length shifted down, saturated at the top entry
  function automatic int cell_of(input logic [15:0] len);
    logic [15:0] ix;
    ix = len >> shift_q;
    return (ix > 16'd255) ? 255 : int'(ix);
  endfunction

  // Advance the shaper state by one command and return its result
  function automatic tbs_pkg::result_t shape_step(input shaper_cmd_t c);
    tbs_pkg::result_t r;
    logic [31:0] span;
    logic [31:0] total;
    longint      margin;
    longint      lack;
    int          ix;
    r = '0;
    case (c.op)
      tbs_pkg::OP_ENQUEUE: begin
        total = {8'd0, backlog_q} + {16'd0, c.len};
        if (total <= {8'd0, max_backlog_q}) begin
          backlog_q  = total[23:0];
          r.admitted = 1'b1;
        end
      end
      tbs_pkg::OP_DEQUEUE: begin
        if (c.head) begin
          // wrapping elapsed time, capped at the bucket depth
          span = c.now - checkpoint_q;
          if (span > {8'd0, depth_q}) span = {8'd0, depth_q};
          ix = cell_of(c.len);
          margin = {32'd0, span} + {40'd0, tokens_q} - {40'd0, cost_q[ix]};
          if (margin >= 0) begin
            checkpoint_q = c.now;
            tokens_q = (margin > $signed({40'd0, depth_q})) ? depth_q : margin[23:0];
            backlog_q = ({8'd0, c.len} >= backlog_q) ? 24'd0 : backlog_q - c.len;
            r.send_now = 1'b1;
          end else begin
            lack = -margin;
            r.wait_us = lack[23:0];
          end
        end
      end
      tbs_pkg::OP_TBL_WR: begin
        cost_q[c.entry_index] = c.entry_value;
        cost_loaded[c.entry_index] = 1'b1;
      end
      tbs_pkg::OP_FLUSH: begin
        backlog_q    = 24'd0;
        checkpoint_q = c.now;
        tokens_q     = depth_q;
      end
    endcase
    r.backlog = backlog_q;
    return r;
  endfunction

  // Cycles one side holds off before its next transfer; now and then a
  // stretch of back-to-back transfers
  function automatic int draw_wait(input int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) calm_left[side] = $urandom_range(8, 40);
    return $urandom_range(0, 9);
  endfunction

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------

  // Present one command after a random gap, hold it until the transfer,
  // then record what the shaper must answer
  task automatic issue(input shaper_cmd_t c, input bit known,
                       input tbs_pkg::result_t want);
    int               gap;
    tbs_pkg::result_t got;
    gap = draw_wait(SIDE_SRC);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    op            <= c.op;
    now           <= c.now;
    packet_length <= c.len;
    head_present  <= c.head;
    entry_index   <= c.entry_index;
    entry_value   <= c.entry_value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = shape_step(c);
    shaper_results.push_back(known ? want : got);
  endtask

  // Drop valid and let every outstanding result come back
  task automatic drain_pipe();
    in_valid <= 1'b0;
    @(posedge clk);
    while (shaper_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write one register while the block is idle and mirror it
  task automatic load_reg(input logic [tbs_pkg::CFG_IDX_W-1:0] idx,
                          input logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tbs_pkg::REG_MAX_BACKLOG:  max_backlog_q = val;
      tbs_pkg::REG_BUCKET_DEPTH: depth_q = val;
      tbs_pkg::REG_CELL_SHIFT:   shift_q = val[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Directed rows
  // ---------------------------------------------------------------------
  function automatic void add_reg(input logic [1:0] idx, input logic [23:0] val);
    stim_row_t row;
    row = '0;
    row.reg_wr  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_cmd(input tbs_pkg::op_t o, input logic [31:0] t,
                                  input logic [15:0] len,
                                  input logic head, input logic [7:0] ix,
                                  input logic [23:0] v);
    stim_row_t row;
    row = '0;
    row.cmd.op          = o;
    row.cmd.now         = t;
    row.cmd.len         = len;
    row.cmd.head        = head;
    row.cmd.entry_index = ix;
    row.cmd.entry_value = v;
    stim_rows.push_back(row);
  endfunction

  // Pin the result of the row just added
  function automatic void known(input logic adm, input logic snd, input logic [23:0] wt,
                                input logic [23:0] bl);
    stim_row_t row;
    row = stim_rows.pop_back();
    row.known = 1'b1;
    row.want  = '{admitted: adm, send_now: snd, wait_us: wt, backlog: bl};
    stim_rows.push_back(row);
  endfunction

  function automatic void build_rows();
    // registers still at reset: zero limit admits only an empty packet
    add_cmd(tbs_pkg::OP_ENQUEUE, 32'd0, 16'd0, 1'b0, 8'd0, 24'd0);
    known(1'b1, 1'b0, 24'd0, 24'd0);
    add_cmd(tbs_pkg::OP_ENQUEUE, 32'd0, 16'd1, 1'b0, 8'd0, 24'd0);
    known(1'b0, 1'b0, 24'd0, 24'd0);
    // empty queue: nothing moves
    add_cmd(tbs_pkg::OP_DEQUEUE, 32'd0, 16'hFFFF, 1'b0, 8'hFF, 24'hFFFFFF);
    known(1'b0, 1'b0, 24'd0, 24'd0);
    add_cmd(tbs_pkg::OP_FLUSH, 32'hFFFF_FFFF, 16'd0, 1'b0, 8'd0, 24'd0);
    known(1'b0, 1'b0, 24'd0, 24'd0);
    add_reg(tbs_pkg::REG_MAX_BACKLOG, 24'hFFFFFF);
    add_reg(tbs_pkg::REG_BUCKET_DEPTH, 24'd1000);
    add_reg(REG_UNMAPPED, 24'hFFFFFF);
    // table extremes
    add_cmd(tbs_pkg::OP_TBL_WR, 32'd0, 16'd0, 1'b0, 8'd0, 24'd0);
    known(1'b0, 1'b0, 24'd0, 24'd0);
    add_cmd(tbs_pkg::OP_TBL_WR, 32'd0, 16'd0, 1'b0, 8'd255, 24'hFFFFFF);
    known(1'b0, 1'b0, 24'd0, 24'd0);
    add_cmd(tbs_pkg::OP_TBL_WR, 32'd0, 16'd0, 1'b0, 8'd100, 24'd500);
    known(1'b0, 1'b0, 24'd0, 24'd0);
    add_cmd(tbs_pkg::OP_ENQUEUE, 32'd0, 16'hFFFF, 1'b0, 8'd0, 24'd0);
    known(1'b1, 1'b0, 24'd0, 24'hFFFF);
    add_cmd(tbs_pkg::OP_ENQUEUE, 32'd0, 16'hFFFF, 1'b0, 8'd0, 24'd0);
    // free packet, elapsed wraps through zero
    add_cmd(tbs_pkg::OP_DEQUEUE, 32'd0, 16'd0, 1'b1, 8'd0, 24'd0);
    // short of tokens, then enough
    add_cmd(tbs_pkg::OP_DEQUEUE, 32'd200, 16'd100, 1'b1, 8'd0, 24'd0);
    add_cmd(tbs_pkg::OP_DEQUEUE, 32'd800, 16'd100, 1'b1, 8'd0, 24'd0);
    // longest packet saturates onto the top entry
    add_cmd(tbs_pkg::OP_DEQUEUE, 32'd900, 16'hFFFF, 1'b1, 8'd0, 24'd0);
    add_cmd(tbs_pkg::OP_FLUSH, 32'hFFFF_FFF0, 16'd0, 1'b0, 8'd0, 24'd0);
    known(1'b0, 1'b0, 24'd0, 24'd0);
    // time wraps forward, and the send outruns the backlog
    add_cmd(tbs_pkg::OP_DEQUEUE, 32'd5, 16'd100, 1'b1, 8'd0, 24'd0);
    // time runs backwards: full bucket, level capped at depth
    add_cmd(tbs_pkg::OP_DEQUEUE, 32'd3, 16'd100, 1'b1, 8'd0, 24'd0);
    add_reg(tbs_pkg::REG_CELL_SHIFT, 24'hFFFFFF);
    add_cmd(tbs_pkg::OP_TBL_WR, 32'd0, 16'd0, 1'b0, 8'd1, 24'd7);
    add_cmd(tbs_pkg::OP_DEQUEUE, 32'd10, 16'hFFFF, 1'b1, 8'd0, 24'd0);
    // tail drop right at the limit
    add_reg(tbs_pkg::REG_MAX_BACKLOG, 24'd1000);
    add_cmd(tbs_pkg::OP_ENQUEUE, 32'd0, 16'd1000, 1'b0, 8'd0, 24'd0);
    known(1'b1, 1'b0, 24'd0, 24'd1000);
    add_cmd(tbs_pkg::OP_ENQUEUE, 32'd0, 16'd1, 1'b0, 8'd0, 24'd0);
    known(1'b0, 1'b0, 24'd0, 24'd1000);
    add_reg(tbs_pkg::REG_BUCKET_DEPTH, 24'hFFFFFF);
    add_cmd(tbs_pkg::OP_FLUSH, 32'd0, 16'd0, 1'b0, 8'd0, 24'd0);
    known(1'b0, 1'b0, 24'd0, 24'd0);
    add_cmd(tbs_pkg::OP_DEQUEUE, 32'd0, 16'd0, 1'b1, 8'd0, 24'd0);
  endfunction

  // ---------------------------------------------------------------------
  // Random commands
  // ---------------------------------------------------------------------

  // Transmit cost: mostly comparable to the bucket, sometimes anything
  function automatic logic [23:0] draw_cost();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 24'd0;
    if (r < 15) return 24'($urandom);
    return 24'($urandom_range(0, 1500));
  endfunction

  function automatic logic [15:0] draw_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 16'hFFFF;
    if (r < 8) return 16'd0;
    if (r < 20) return 16'($urandom);
    return 16'($urandom_range(40, 1600));
  endfunction

  // Time mostly moves forward in small steps; jumps and rewinds are rare
  function automatic logic [31:0] tick_clock();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) clock_us = clock_us + $urandom_range(0, 400);
    else if (r < 92) clock_us = clock_us + $urandom_range(400, 5000);
    else if (r < 96) clock_us = $urandom;
    else clock_us = clock_us - $urandom_range(0, 100);
    return clock_us;
  endfunction

  function automatic shaper_cmd_t random_cmd();
    shaper_cmd_t c;
    int          pick;
    int          ix;
    c.now         = tick_clock();
    c.len         = draw_len();
    c.head        = ($urandom_range(0, 9) != 0);
    c.entry_index = 8'($urandom);
    c.entry_value = draw_cost();
    pick = $urandom_range(0, 99);
    if (pick < 38) c.op = tbs_pkg::OP_ENQUEUE;
    else if (pick < 78) c.op = tbs_pkg::OP_DEQUEUE;
    else if (pick < 95) c.op = tbs_pkg::OP_TBL_WR;
    else c.op = tbs_pkg::OP_FLUSH;
    // a dequeue must find its cost loaded; load that entry instead
    if (c.op == tbs_pkg::OP_DEQUEUE && c.head) begin
      ix = cell_of(c.len);
      if (!cost_loaded[ix]) begin
        c.op = tbs_pkg::OP_TBL_WR;
        c.entry_index = 8'(ix);
      end
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------
  // Result side: random stall, compare each transfer with the oldest
  // awaited result
  // ---------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PRINT_CAP)
      $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  int hold_cycles;

  always @(posedge clk) begin : result_side
    tbs_pkg::result_t want;
    if (rst) begin
      out_stall   <= 1'b0;
      hold_cycles = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (shaper_results.size() == 0) begin
          report_mismatch("result with nothing awaited, backlog", 32'(backlog), 32'd0);
        end else begin
          want = shaper_results.pop_front();
          if (admitted !== want.admitted)
            report_mismatch("admitted", 32'(admitted), 32'(want.admitted));
          if (send_now !== want.send_now)
            report_mismatch("send_now", 32'(send_now), 32'(want.send_now));
          if (wait_us !== want.wait_us)
            report_mismatch("wait_us", 32'(wait_us), 32'(want.wait_us));
          if (backlog !== want.backlog)
            report_mismatch("backlog", 32'(backlog), 32'(want.backlog));
        end
        hold_cycles = draw_wait(SIDE_SINK);
      end
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on the whole run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin : run
    stim_row_t        row;
    shaper_cmd_t      c;
    tbs_pkg::result_t none;
    logic [23:0]      lim;
    logic [23:0]      dep;
    logic [3:0]       sh;
    mismatches    = 0;
    cycle_count   = 0;
    calm_left[0]  = 0;
    calm_left[1]  = 0;
    max_backlog_q = '0;
    depth_q       = '0;
    shift_q       = '0;
    backlog_q     = '0;
    tokens_q      = '0;
    checkpoint_q  = '0;
    cost_loaded   = '0;
    none          = '0;
    clock_us      = '0;
    for (int i = 0; i < 256; i++) cost_q[i] = '0;
    build_rows();

    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // walk the directed rows; register writes wait for an idle block
    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.reg_wr) begin
        drain_pipe();
        load_reg(row.reg_idx, row.reg_val);
      end else begin
        issue(row.cmd, row.known, row.want);
      end
    end

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin lim = 24'hFFFFFF; dep = 24'hFFFFFF; sh = 4'd0; end
        1: begin lim = 24'd0; dep = 24'd0; sh = 4'd15; end
        default: begin
          lim = 24'($urandom_range(0, 40000));
          dep = 24'($urandom_range(0, 3000));
          sh  = 4'($urandom_range(0, 15));
        end
      endcase
      drain_pipe();
      load_reg(tbs_pkg::REG_MAX_BACKLOG, lim);
      load_reg(tbs_pkg::REG_BUCKET_DEPTH, dep);
      // upper bits of the shift write are junk the block must ignore
      load_reg(tbs_pkg::REG_CELL_SHIFT, {20'($urandom), sh});
      // one phase crosses the 32-bit wrap of the time counter
      if (p == 3) clock_us = 32'hFFFF_0000;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        c = random_cmd();
        issue(c, 1'b0, none);
      end
    end

    drain_pipe();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
